// File: sv/ptdg_pkg.sv
// Package for the page table descriptor generator.
// Holds the constants, codes and types shared by the generator's modules.
// Has no dependencies.
`default_nettype none

package ptdg_pkg;

    // Input mode codes.
    localparam logic [1:0] MODE_LEVEL_ONE = 2'd0;
    localparam logic [1:0] MODE_FW_PAGE   = 2'd1;
    localparam logic [1:0] MODE_OCM_PAGE  = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FW_TABLE_BASE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OCM_TABLE_BASE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_END       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DMA_FIRST      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DMA_LAST       = 3'd4;

    // Reset values.
    localparam logic [31:0] CODE_END_RESET  = 32'h0010_0000;
    localparam logic [11:0] DMA_FIRST_RESET = 12'd2;
    localparam logic [11:0] DMA_LAST_RESET  = 12'd383;
    localparam logic [31:0] PAGE_ROUND      = 32'h0000_0FFF;

    // Section numbers (address bits 31..20).
    localparam logic [11:0] SECT_FIRMWARE = 12'h001;
    localparam logic [11:0] SECT_DDR_LAST = 12'h3FF;
    localparam logic [11:0] SECT_OCM_HIGH = 12'hFFF;
    localparam logic [11:0] SECT_DEV_A    = 12'h43C;
    localparam logic [11:0] SECT_DEV_B    = 12'h83C;
    localparam logic [11:0] SECT_DEV_C    = 12'hE00;
    localparam logic [11:0] SECT_DEV_D    = 12'hF80;
    localparam logic [11:0] SECT_DEV_E    = 12'hF8F;

    // Lowest on-chip page number (address bits 31..12).
    localparam logic [19:0] PAGE_OCM_LOW = 20'hFFFC0;

    // Entry attribute bits.
    localparam logic [31:0] SEC_BASE_BITS    = 32'h0000_0402;
    localparam logic [31:0] ATTR_CACHED_XN   = 32'h0001_101C;
    localparam logic [31:0] ATTR_UNCACHED_XN = 32'h0001_1010;
    localparam logic [31:0] ATTR_DEVICE_XN   = 32'h0001_0014;
    localparam logic [31:0] PG_RX_BITS       = 32'h0000_065E;
    localparam logic [31:0] PG_RW_XN_BITS    = 32'h0000_045F;
    localparam logic [31:0] PG_ONCHIP_BITS   = 32'h0000_0453;
    localparam logic [31:0] COARSE_TYPE      = 32'h0000_0001;

    typedef struct packed {
        logic [21:0] fw_table_base;   // bits 31..10 of the firmware table
        logic [21:0] ocm_table_base;  // bits 31..10 of the on-chip table
        logic [19:0] code_page_limit; // rounded code end, page number
        logic [11:0] dma_first;
        logic [11:0] dma_last;
    } cfg_t;

    typedef struct packed {
        logic [31:0] descriptor;
        logic        mapped;
        logic        executable;
        logic        privileged_writable;
        logic        writable_and_executable;
    } result_t;

endpackage

`default_nettype wire

// File: sv/ptdg_cfg_regs.sv
// Configuration registers of the page table descriptor generator.
// Stores only the bits that the entry logic uses. Depends on ptdg_pkg.
`default_nettype none

module ptdg_cfg_regs
    import ptdg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    output cfg_t                        cfg
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [31:0] code_end_rounded;
    logic [31:0] code_end_reset_rounded;

    // The rounding add wraps at 32 bits: an end above the last page start gives limit 0.
    assign code_end_rounded       = cfg_data + PAGE_ROUND;
    assign code_end_reset_rounded = CODE_END_RESET + PAGE_ROUND;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FW_TABLE_BASE:  cfg_next.fw_table_base   = cfg_data[31:10];
                CFG_OCM_TABLE_BASE: cfg_next.ocm_table_base  = cfg_data[31:10];
                CFG_CODE_END:       cfg_next.code_page_limit = code_end_rounded[31:12];
                CFG_DMA_FIRST:      cfg_next.dma_first       = cfg_data[11:0];
                CFG_DMA_LAST:       cfg_next.dma_last        = cfg_data[11:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fw_table_base   <= '0;
            cfg_reg.ocm_table_base  <= '0;
            cfg_reg.code_page_limit <= code_end_reset_rounded[31:12];
            cfg_reg.dma_first       <= DMA_FIRST_RESET;
            cfg_reg.dma_last        <= DMA_LAST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/ptdg_entry_logic.sv
// Combinational entry builder of the page table descriptor generator.
// Classifies the address for the given mode and forms the entry and flags.
// Depends on ptdg_pkg.
`default_nettype none

module ptdg_entry_logic
    import ptdg_pkg::*;
(
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] address,
    input  wire cfg_t        cfg,
    output result_t          result
);

    logic [11:0] sect;
    logic [19:0] page;
    logic [31:0] sect_addr;
    logic [31:0] page_addr;
    logic        in_dma;
    logic        is_device;
    logic [31:0] l1_entry;
    logic [31:0] fw_entry;
    logic [31:0] ocm_entry;
    logic [31:0] entry;
    logic        page_mode;
    logic        small_page;
    logic        ex;
    logic        pw;

    assign sect      = address[31:20];
    assign page      = address[31:12];
    assign sect_addr = {sect, 20'd0};
    assign page_addr = {page, 12'd0};
    assign in_dma    = (sect >= cfg.dma_first) && (sect <= cfg.dma_last);
    assign is_device = (sect == SECT_DEV_A) || (sect == SECT_DEV_B) || (sect == SECT_DEV_C)
                    || (sect == SECT_DEV_D) || (sect == SECT_DEV_E);

    always_comb
    begin
        // The firmware section is always a coarse pointer, ahead of the DDR range check.
        if (sect == SECT_FIRMWARE)
            l1_entry = {cfg.fw_table_base, 10'd0} | COARSE_TYPE;
        else if (sect != 12'd0 && sect <= SECT_DDR_LAST)
            l1_entry = sect_addr | SEC_BASE_BITS | (in_dma ? ATTR_UNCACHED_XN : ATTR_CACHED_XN);
        else if (is_device)
            l1_entry = sect_addr | SEC_BASE_BITS | ATTR_DEVICE_XN;
        else if (sect == SECT_OCM_HIGH)
            l1_entry = {cfg.ocm_table_base, 10'd0} | COARSE_TYPE;
        else
            l1_entry = '0;
    end

    always_comb
    begin
        if (sect != SECT_FIRMWARE)
            fw_entry = '0;
        else if (page < cfg.code_page_limit)
            fw_entry = page_addr | PG_RX_BITS;
        else
            fw_entry = page_addr | PG_RW_XN_BITS;
    end

    assign ocm_entry = (sect == SECT_OCM_HIGH && page >= PAGE_OCM_LOW)
                     ? (page_addr | PG_ONCHIP_BITS) : '0;

    always_comb
    begin
        case (mode)
            MODE_LEVEL_ONE:
            begin
                entry     = l1_entry;
                page_mode = 1'b0;
            end
            MODE_FW_PAGE:
            begin
                entry     = fw_entry;
                page_mode = 1'b1;
            end
            MODE_OCM_PAGE:
            begin
                entry     = ocm_entry;
                page_mode = 1'b1;
            end
            default:
            begin
                entry     = '0;
                page_mode = 1'b0;
            end
        endcase
    end

    // Bit 1 marks a small page, bit 0 is execute-never, bit 4 is AP[0] and bit 9 is APX.
    assign small_page = page_mode & entry[1];
    assign ex         = small_page & ~entry[0];
    assign pw         = small_page & entry[4] & ~entry[9];

    assign result.descriptor              = entry;
    assign result.mapped                  = (entry != '0);
    assign result.executable              = ex;
    assign result.privileged_writable     = pw;
    assign result.writable_and_executable = ex & pw;

endmodule

`default_nettype wire

// File: sv/page_table_descriptor_generator_core.sv
// Page table descriptor generator, top level.
// Pipeline: an accepted transaction is held in the input register, its entry in the result register.
// Throughput: one transaction per cycle while out_ready is high; the entry logic is one pass.
// Reset: asynchronous, active low; clears both pipeline valids and restores register defaults.
// Depends on ptdg_pkg, ptdg_cfg_regs and ptdg_entry_logic.
`default_nettype none

module page_table_descriptor_generator_core
    import ptdg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             mode,
    input  wire logic [31:0]            address,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [31:0]                 descriptor,
    output logic                        mapped,
    output logic                        executable,
    output logic                        privileged_writable,
    output logic                        writable_and_executable,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    cfg_t        cfg;
    result_t     entry_result;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  mode_reg;
    logic [31:0] address_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    logic        result_load;
    logic        in_load;

    ptdg_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptdg_entry_logic u_entry_logic
    (
        .mode    (mode_reg),
        .address (address_reg),
        .cfg     (cfg),
        .result  (entry_result)
    );

    // The result register takes the held entry whenever it is empty or being drained.
    assign result_load    = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || result_load;
    assign in_load        = in_valid && in_ready;
    assign in_valid_next  = in_load || (in_valid_reg && !result_load);
    assign out_valid_next = result_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            mode_reg    <= mode;
            address_reg <= address;
        end
        if (result_load)
        begin
            result_reg <= entry_result;
        end
    end

    assign out_valid               = out_valid_reg;
    assign descriptor              = result_reg.descriptor;
    assign mapped                  = result_reg.mapped;
    assign executable              = result_reg.executable;
    assign privileged_writable     = result_reg.privileged_writable;
    assign writable_and_executable = result_reg.writable_and_executable;

`ifndef SYNTH
    a_mapped_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mapped == (descriptor != 32'd0)))
        else $error("mapped flag disagrees with descriptor");

    a_wx_both: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && writable_and_executable) |-> (executable && privileged_writable))
        else $error("writable_and_executable without both flags");

    a_entry_moves: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> out_valid)
        else $error("entry taken into result register but no result shown");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages are stalled");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for page_table_descriptor_generator_core.
// Drives address and mode transactions under several register settings and idle patterns, and
// checks each result against typed-in rows or a predictor. Depends on ptdg_pkg and the core RTL.
module tb;
    import ptdg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [31:0] SECT_BITS = 32'hFFF0_0000;
    localparam logic [31:0] PAGE_BITS = 32'hFFFF_F000;
    localparam int RANDOM_PER_PHASE = 86;
    localparam int NUM_PHASES = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 60;

    typedef struct {
        logic [1:0]  m;
        logic [31:0] a;
        bit          typed;
        result_t     r;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             mode = '0;
    logic [31:0]            address = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b1;
    logic [31:0]            descriptor;
    logic                   mapped;
    logic                   executable;
    logic                   privileged_writable;
    logic                   writable_and_executable;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    // Typed-in expectation that travels with the current transaction.
    bit      row_typed = 1'b0;
    result_t row_expect = '0;

    // Shadow copy of the configuration registers.
    logic [31:0] fw_table_base = '0;
    logic [31:0] ocm_table_base = '0;
    logic [31:0] code_end = CODE_END_RESET;
    logic [11:0] dma_first = DMA_FIRST_RESET;
    logic [11:0] dma_last = DMA_LAST_RESET;

    result_t   pending_entries[$];
    stim_row_t directed_rows[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        errors = 0;
    int        entries_sent = 0;
    int        entries_checked = 0;
    int        settings_used = 1;
    int        cycles = 0;

    page_table_descriptor_generator_core dut (
        .clk, .rst_n, .in_valid, .in_ready, .mode, .address, .out_valid, .out_ready,
        .descriptor, .mapped, .executable, .privileged_writable, .writable_and_executable,
        .cfg_we, .cfg_index, .cfg_data
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t predict_entry(input logic [1:0] m, input logic [31:0] a);
        logic [31:0] sect;
        logic [31:0] page;
        logic [31:0] limit;
        logic [11:0] num;
        logic        page_mode;
        logic        ex;
        logic        pw;
        result_t     r;
        sect = a & SECT_BITS;
        page = a & PAGE_BITS;
        num = a[31:20];
        limit = (code_end + PAGE_ROUND) & PAGE_BITS;
        r = '0;
        page_mode = 1'b0;
        case (m)
            MODE_LEVEL_ONE: begin
                // The firmware section wins over the DMA window.
                if (num == SECT_FIRMWARE)
                    r.descriptor = {fw_table_base[31:10], 10'b0} | COARSE_TYPE;
                else if (num >= SECT_FIRMWARE && num <= SECT_DDR_LAST)
                    r.descriptor = sect | SEC_BASE_BITS |
                        ((num >= dma_first && num <= dma_last) ? ATTR_UNCACHED_XN
                                                               : ATTR_CACHED_XN);
                else if (num == SECT_DEV_A || num == SECT_DEV_B || num == SECT_DEV_C ||
                         num == SECT_DEV_D || num == SECT_DEV_E)
                    r.descriptor = sect | SEC_BASE_BITS | ATTR_DEVICE_XN;
                else if (num == SECT_OCM_HIGH)
                    r.descriptor = {ocm_table_base[31:10], 10'b0} | COARSE_TYPE;
            end
            MODE_FW_PAGE: begin
                page_mode = 1'b1;
                if (num == SECT_FIRMWARE)
                    r.descriptor = page | ((page < limit) ? PG_RX_BITS : PG_RW_XN_BITS);
            end
            MODE_OCM_PAGE: begin
                page_mode = 1'b1;
                if (num == SECT_OCM_HIGH && a[31:12] >= PAGE_OCM_LOW)
                    r.descriptor = page | PG_ONCHIP_BITS;
            end
            default: ;
        endcase
        ex = page_mode && r.descriptor[1] && !r.descriptor[0];
        pw = page_mode && r.descriptor[1] && r.descriptor[4] && !r.descriptor[9];
        r.mapped = (r.descriptor != '0);
        r.executable = ex;
        r.privileged_writable = pw;
        r.writable_and_executable = ex && pw;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [1:0] m, input logic [31:0] a,
                                         input bit typed, input logic [31:0] d,
                                         input logic mp, input logic ex, input logic pw,
                                         input logic wx);
        stim_row_t row;
        row.m = m;
        row.a = a;
        row.typed = typed;
        row.r = '{descriptor: d, mapped: mp, executable: ex, privileged_writable: pw,
                  writable_and_executable: wx};
        return row;
    endfunction

    // Addresses are steered toward section and page boundaries that change the entry.
    function automatic logic [31:0] pick_address(input logic [1:0] m);
        logic [11:0] num;
        logic [19:0] pg;
        logic [31:0] limit;
        if ($urandom_range(9) < 2)
            return $urandom;
        case (m)
            MODE_LEVEL_ONE: begin
                case ($urandom_range(12))
                    0: num = 12'h000;
                    1: num = SECT_FIRMWARE;
                    2: num = dma_first - 12'd1;
                    3: num = dma_first;
                    4: num = dma_last;
                    5: num = dma_last + 12'd1;
                    6: num = SECT_DDR_LAST;
                    7: num = SECT_DDR_LAST + 12'd1;
                    8: num = SECT_OCM_HIGH;
                    9: begin
                        case ($urandom_range(4))
                            0: num = SECT_DEV_A;
                            1: num = SECT_DEV_B;
                            2: num = SECT_DEV_C;
                            3: num = SECT_DEV_D;
                            default: num = SECT_DEV_E;
                        endcase
                    end
                    10: num = 12'($urandom_range(1, SECT_DDR_LAST));
                    default: num = 12'($urandom);
                endcase
                return {num, 20'($urandom)};
            end
            MODE_FW_PAGE: begin
                limit = (code_end + PAGE_ROUND) & PAGE_BITS;
                if ($urandom_range(1) == 0)
                    pg = limit[31:12] + 20'($urandom_range(4)) - 20'd2;
                else
                    pg = {SECT_FIRMWARE, 8'($urandom)};
                if ($urandom_range(7) != 0)
                    pg[19:8] = SECT_FIRMWARE;
                return {pg, 12'($urandom)};
            end
            MODE_OCM_PAGE: begin
                if ($urandom_range(2) == 0)
                    pg = PAGE_OCM_LOW + 20'($urandom_range(2)) - 20'd1;
                else
                    pg = 20'hFFFB0 + 20'($urandom_range(20'h4F));
                return {pg, 12'($urandom)};
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("tb: mismatch on %s at result %0d: got %h, expected %h",
                     what, entries_checked, got, want);
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        result_t want;
        if (in_valid && in_ready)
            pending_entries.push_back(row_typed ? row_expect : predict_entry(mode, address));
        if (out_valid && out_ready) begin
            if (pending_entries.size() == 0) begin
                report_mismatch("unexpected transaction", descriptor, '0);
            end else begin
                want = pending_entries.pop_front();
                if (descriptor !== want.descriptor)
                    report_mismatch("descriptor", descriptor, want.descriptor);
                if (mapped !== want.mapped)
                    report_mismatch("mapped", 32'(mapped), 32'(want.mapped));
                if (executable !== want.executable)
                    report_mismatch("executable", 32'(executable), 32'(want.executable));
                if (privileged_writable !== want.privileged_writable)
                    report_mismatch("privileged_writable", 32'(privileged_writable),
                                    32'(want.privileged_writable));
                if (writable_and_executable !== want.writable_and_executable)
                    report_mismatch("writable_and_executable", 32'(writable_and_executable),
                                    32'(want.writable_and_executable));
            end
            entries_checked++;
        end
    end

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_entry(input stim_row_t row);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        mode <= row.m;
        address <= row.a;
        row_typed <= row.typed;
        row_expect <= row.r;
        do @(posedge clk); while (!in_ready);
        entries_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_entries.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_FW_TABLE_BASE:  fw_table_base = value;
            CFG_OCM_TABLE_BASE: ocm_table_base = value;
            CFG_CODE_END:       code_end = value;
            CFG_DMA_FIRST:      dma_first = value[11:0];
            CFG_DMA_LAST:       dma_last = value[11:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Upper bits of the section registers carry noise that the block must drop.
    task automatic apply_setting(input logic [31:0] fw, input logic [31:0] ocm,
                                 input logic [31:0] ce, input logic [11:0] first,
                                 input logic [11:0] last);
        logic [CFG_INDEX_W-1:0] idx;
        write_reg(CFG_FW_TABLE_BASE, fw);
        write_reg(CFG_OCM_TABLE_BASE, ocm);
        write_reg(CFG_CODE_END, ce);
        write_reg(CFG_DMA_FIRST, {20'($urandom), first});
        write_reg(CFG_DMA_LAST, {20'($urandom), last});
        // Indexes past the last register must be ignored.
        for (idx = CFG_DMA_LAST + 1'b1; idx != '0; idx++)
            write_reg(idx, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    initial begin
        stim_row_t row;
        logic [1:0] m;
        int pick;
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h0000_0000, 1, 32'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h0010_0000, 1, 32'h1, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h001F_FFFF, 1, 32'h1, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h0020_0000, 1, 32'h0021_1412,
                                       1, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h17F0_0000, 0, '0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h1800_0000, 0, '0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h3FFF_FFFF, 1, 32'h3FF1_141E,
                                       1, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h4000_0000, 1, 32'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h43C1_2345, 1, 32'h43C1_0416,
                                       1, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'h83C0_0000, 0, '0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'hE00A_BCDE, 0, '0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'hF800_0000, 0, '0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'hF8F0_0100, 0, '0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_LEVEL_ONE, 32'hFFFF_FFFF, 1, 32'h1, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_FW_PAGE, 32'h0000_0000, 1, 32'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_FW_PAGE, 32'h0010_0000, 1, 32'h0010_045F,
                                       1, 0, 1, 0));
        directed_rows.push_back(mk_row(MODE_FW_PAGE, 32'h001F_FFFF, 1, 32'h001F_F45F,
                                       1, 0, 1, 0));
        directed_rows.push_back(mk_row(MODE_FW_PAGE, 32'h0020_0000, 1, 32'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_OCM_PAGE, 32'hFFFC_0000, 1, 32'hFFFC_0453,
                                       1, 0, 1, 0));
        directed_rows.push_back(mk_row(MODE_OCM_PAGE, 32'hFFFB_FFFF, 1, 32'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_OCM_PAGE, 32'hFFFF_FFFF, 1, 32'hFFFF_F453,
                                       1, 0, 1, 0));
        directed_rows.push_back(mk_row(MODE_OCM_PAGE, 32'h0000_0000, 1, 32'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_UNUSED, 32'hFFFF_FFFF, 1, 32'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_UNUSED, 32'h0010_0000, 1, 32'h0, 0, 0, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed rows run on the register values left by reset.
        foreach (directed_rows[i])
            send_entry(directed_rows[i]);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: ;
                1: apply_setting('0, '0, '0, '0, '0);
                2: apply_setting('1, '1, '1, '1, '1);
                3: apply_setting($urandom, $urandom, 32'h0018_0000, '0, '1);
                4: apply_setting($urandom, $urandom, 32'h001F_F001, 12'd300, 12'd100);
                5: apply_setting($urandom, $urandom,
                                 32'h0010_0000 + $urandom_range(32'h0010_0000),
                                 12'($urandom_range(SECT_DDR_LAST)),
                                 12'($urandom_range(SECT_DDR_LAST)));
                default: apply_setting($urandom, $urandom, $urandom, 12'($urandom),
                                       12'($urandom));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                m = (pick < 40) ? MODE_LEVEL_ONE : (pick < 70) ? MODE_FW_PAGE :
                    (pick < 95) ? MODE_OCM_PAGE : MODE_UNUSED;
                row = mk_row(m, pick_address(m), 0, '0, 0, 0, 0, 0);
                send_entry(row);
            end
            drain();
        end

        if (pending_entries.size() != 0)
            report_mismatch("results never delivered", pending_entries.size(), '0);
        $display("tb: %0d transactions sent and %0d results checked", entries_sent,
                 entries_checked);
        $display("tb: %0d register settings, four handshake idle patterns, %0d mismatches",
                 settings_used, errors);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
